// File: rtl/dqp_pkg.sv
// ----------------------------------------------------------------------------
// dqp_pkg: shared types and constants for the detection post-processing block
// Exponent table, controller states and controller/datapath command structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dqp_pkg;

  localparam int unsigned LOGIT_W = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned BOX_W   = 16;
  localparam int unsigned LABEL_W = 7;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CORNER_W = 17;
  localparam logic [10:0] LOG2E_Q10 = 11'd1477;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP,
    ST_MUL,
    ST_ACC,
    ST_SEXP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exp_upd;
    logic mul_upd;
    logic acc_upd;
    logic sexp;
    logic div_start;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic has_candidate;
    logic div_done;
    logic pass;
  } status_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/detr_query_postprocess_core.sv
// ----------------------------------------------------------------------------
// detr_query_postprocess_core: per-query softmax, argmax and box conversion
//
// channel  dir  tdata (low to high)                           tlast
// s_axis   in   logit[15:0], box_cx, box_cy, box_w, box_h     last_class
// m_axis   out  score[15:0], label[22:16], x_min, y_min,      -
//               x_max, y_max (17 bits each), zero pad
// cfg      in   min score (Q0.16), written when cfg_we high
//
// Each logit is accepted, passed through the exp table, multiplied and
// accumulated before the next is taken. The last logit of a query with a
// candidate adds an exp step, the 16-step divider and a result step.
// Synchronous reset clears query state and sets the minimum score to 32768.
// A waiting result does not block input; the next query end holds its score
// step until m_axis has taken the earlier result.
// ----------------------------------------------------------------------------
`default_nettype none

module detr_query_postprocess_core #(
  parameter int unsigned MAX_CLASSES = 128
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,  // logit, box_cx, box_cy, box_w, box_h
  input  wire logic         s_axis_tlast,  // last_class
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [95:0]  m_axis_tdata   // score, label, x_min, y_min, x_max, y_max
);

  logic [15:0] threshold;
  dqp_pkg::cmd_t    cmd;
  dqp_pkg::status_t status;
  logic [15:0] o_score;
  logic [6:0]  o_label;
  logic [16:0] o_xmin, o_ymin, o_xmax, o_ymax;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd32768;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  dqp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd(cmd), .status(status)
  );

  dqp_datapath #(.MAX_CLASSES(MAX_CLASSES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .cfg_threshold(threshold),
    .in_logit(s_axis_tdata[15:0]), .in_last(s_axis_tlast),
    .in_cx(s_axis_tdata[31:16]), .in_cy(s_axis_tdata[47:32]),
    .in_w(s_axis_tdata[63:48]), .in_h(s_axis_tdata[79:64]),
    .o_score(o_score), .o_label(o_label), .o_xmin(o_xmin), .o_ymin(o_ymin),
    .o_xmax(o_xmax), .o_ymax(o_ymax)
  );

  assign m_axis_tdata = {5'b0, o_ymax, o_xmax, o_ymin, o_xmin, o_label, o_score};

endmodule

`default_nettype wire

// File: rtl/dqp_exp.sv
// ----------------------------------------------------------------------------
// dqp_exp: registered exp(-d) approximation
// Two stages: scale by log2(e), then table interpolation and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_exp (
  input  wire logic        clk,
  input  wire logic [15:0] d,
  output logic      [16:0] e
);

  logic [26:0] t;
  logic [4:0]  idx;
  logic [16:0] p0;
  logic [16:0] p1;
  logic [15:0] diff;
  logic [31:0] prod;
  logic [16:0] m;

  always_ff @(posedge clk) begin
    t <= {11'd0, d} * {16'd0, dqp_pkg::LOG2E_Q10};
  end

  always_comb begin
    idx  = {1'b0, t[19:16]};
    p0   = dqp_pkg::pow2_tab(idx);
    p1   = dqp_pkg::pow2_tab(idx + 5'd1);
    diff = 16'(p0 - p1);
    prod = diff * t[15:0];
    m    = p0 - 17'(prod[31:16]);
  end

  always_ff @(posedge clk) begin
    e <= m >> t[26:20];
  end

endmodule

`default_nettype wire

// File: rtl/dqp_div.sv
// ----------------------------------------------------------------------------
// dqp_div: restoring divider, one quotient bit per cycle
// Computes (num << 16) / den, saturated to 16 bits; den = 0 gives 0.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [16:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic      [15:0] quot
);

  logic [33:0] rem;
  logic [16:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic [34:0] trial;

  assign trial = {rem, 1'b0} - {3'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 34'(num);
        q    <= '0;
      end else if (busy) begin
        if (!trial[34]) begin
          rem <= trial[33:0];
          q   <= {q[15:0], 1'b1};
        end else begin
          rem <= {rem[32:0], 1'b0};
          q   <= {q[15:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // 16 steps from rem = num give (num << 16) / den; num >= den sets every bit,
  // which is the saturated value
  assign quot = (den == '0) ? 16'd0 : (q[16] ? 16'hFFFF : q[15:0]);

endmodule

`default_nettype wire

// File: rtl/dqp_datapath.sv
// ----------------------------------------------------------------------------
// dqp_datapath: online softmax, best class tracking, score and box
// Holds query state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_datapath #(
  parameter int unsigned MAX_CLASSES = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dqp_pkg::cmd_t        cmd,
  output dqp_pkg::status_t          status,
  input  wire logic [15:0]          cfg_threshold,
  input  wire logic signed [15:0]   in_logit,
  input  wire logic                 in_last,
  input  wire logic [15:0]          in_cx,
  input  wire logic [15:0]          in_cy,
  input  wire logic [15:0]          in_w,
  input  wire logic [15:0]          in_h,
  output logic [15:0]               o_score,
  output logic [6:0]                o_label,
  output logic [16:0]               o_xmin,
  output logic [16:0]               o_ymin,
  output logic [16:0]               o_xmax,
  output logic [16:0]               o_ymax
);

  localparam int unsigned CNT_W = $clog2(MAX_CLASSES);

  logic signed [15:0] x;
  logic               last;
  logic [15:0]        cx, cy, w, h;
  logic signed [15:0] running_max;
  logic [31:0]        exp_sum;
  logic signed [15:0] best_logit;
  logic [CNT_W-1:0]   best_label;
  logic [CNT_W-1:0]   class_count;
  logic               has_candidate;
  logic               grow;
  logic [15:0]        exp_d;
  logic [16:0]        exp_e;
  logic [16:0]        e_reg;
  logic [48:0]        prod;
  logic [32:0]        sum_add;
  logic               div_done;
  logic [15:0]        quot;

  assign grow = x > running_max;

  always_comb begin
    if (cmd.sexp) begin
      exp_d = 16'(running_max - best_logit);
    end else if (grow) begin
      exp_d = 16'(x - running_max);
    end else begin
      exp_d = 16'(running_max - x);
    end
  end

  dqp_exp u_exp (.clk(clk), .d(exp_d), .e(exp_e));

  dqp_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(e_reg), .den(exp_sum),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.exp_upd) begin
      e_reg <= exp_e;
    end
    if (cmd.mul_upd) begin
      prod <= exp_sum * e_reg;
    end
    if (cmd.load) begin
      x    <= in_logit;
      last <= in_last;
      cx   <= in_cx;
      cy   <= in_cy;
      w    <= in_w;
      h    <= in_h;
    end
  end

  always_comb begin
    if (grow) begin
      sum_add = {1'b0, prod[47:16]} + 33'(dqp_pkg::ONE_Q16);
    end else begin
      sum_add = {1'b0, exp_sum} + 33'(e_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      running_max   <= 16'sh8000;
      exp_sum       <= '0;
      best_logit    <= 16'sh8000;
      best_label    <= '0;
      class_count   <= '0;
      has_candidate <= 1'b0;
    end else if (cmd.acc_upd) begin
      exp_sum <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
      if (grow) begin
        running_max <= x;
      end
      if (!last) begin
        if (!has_candidate || x > best_logit) begin
          best_logit    <= x;
          best_label    <= class_count;
          has_candidate <= 1'b1;
        end
        if (class_count != CNT_W'(MAX_CLASSES - 1)) begin
          class_count <= class_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      o_score <= quot;
      o_label <= 7'(best_label);
      o_xmin  <= 17'({1'b0, cx} - {2'b0, w[15:1]});
      o_ymin  <= 17'({1'b0, cy} - {2'b0, h[15:1]});
      o_xmax  <= 17'({1'b0, cx} + {2'b0, w[15:1]});
      o_ymax  <= 17'({1'b0, cy} + {2'b0, h[15:1]});
    end
  end

  assign status.last          = last;
  assign status.has_candidate = has_candidate;
  assign status.div_done      = div_done;
  assign status.pass          = quot >= cfg_threshold;

endmodule

`default_nettype wire

// File: rtl/dqp_ctrl.sv
// ----------------------------------------------------------------------------
// dqp_ctrl: sequencer for per-item update and end-of-query score
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dqp_pkg::cmd_t          cmd,
  input  wire dqp_pkg::status_t  status
);

  dqp_pkg::state_t state, state_next;
  logic [1:0] wait_cnt, wait_cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dqp_pkg::ST_IDLE;
      wait_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wait_cnt  <= wait_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    wait_cnt_next  = wait_cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      dqp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_ready) begin
          cmd.load      = 1'b1;
          wait_cnt_next = '0;
          state_next    = dqp_pkg::ST_EXP;
        end
      end
      dqp_pkg::ST_EXP: begin
        wait_cnt_next = wait_cnt + 2'd1;
        if (wait_cnt == 2'd2) begin
          cmd.exp_upd = 1'b1;
          state_next  = dqp_pkg::ST_MUL;
        end
      end
      dqp_pkg::ST_MUL: begin
        cmd.mul_upd = 1'b1;
        state_next  = dqp_pkg::ST_ACC;
      end
      dqp_pkg::ST_ACC: begin
        cmd.acc_upd   = 1'b1;
        wait_cnt_next = '0;
        if (!status.last) begin
          state_next = dqp_pkg::ST_IDLE;
        end else if (status.has_candidate) begin
          state_next = dqp_pkg::ST_SEXP;
        end else begin
          cmd.acc_upd = 1'b0;
          cmd.clear   = 1'b1;
          state_next  = dqp_pkg::ST_IDLE;
        end
      end
      dqp_pkg::ST_SEXP: begin
        cmd.sexp = 1'b1;
        // hold until the previous result has left the output register
        if (wait_cnt != 2'd0 || !out_valid) begin
          wait_cnt_next = wait_cnt + 2'd1;
        end
        if (wait_cnt == 2'd2) begin
          cmd.exp_upd = 1'b1;
        end
        if (wait_cnt == 2'd3) begin
          cmd.div_start = 1'b1;
          state_next    = dqp_pkg::ST_DIV;
        end
      end
      dqp_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = dqp_pkg::ST_OUT;
        end
      end
      dqp_pkg::ST_OUT: begin
        cmd.clear      = 1'b1;
        out_valid_next = status.pass;
        state_next     = dqp_pkg::ST_IDLE;
      end
      default: state_next = dqp_pkg::ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == dqp_pkg::ST_IDLE)
    else $error("accept while busy");
  a_out_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == dqp_pkg::ST_OUT)
    else $error("result without query end");

endmodule

`default_nettype wire

// File: tb/detr_query_postprocess_core_test.sv
// ----------------------------------------------------------------------------
// detr_query_postprocess_core_test: self-checking bench for query postprocess
// Streams class logits per query with random gaps and threshold settings,
// predicts softmax score, argmax label and corner box, and checks each output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module detr_query_postprocess_core_test;

  typedef struct packed {
    logic [15:0] box_h;
    logic [15:0] box_w;
    logic [15:0] box_cy;
    logic [15:0] box_cx;
    logic [15:0] logit;
  } logit_item_t;

  typedef struct {
    logit_item_t data;
    logic        last;
  } logit_txn_t;

  typedef struct packed {
    logic [16:0] y_max;
    logic [16:0] x_max;
    logic [16:0] y_min;
    logic [16:0] x_min;
    logic [6:0]  label;
    logic [15:0] score;
  } detection_t;

  localparam int MAX_CLS = 128;
  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;

  detr_query_postprocess_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  logit_txn_t pending_logits[$];
  detection_t expected_dets[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_send = 0;
  bit quiet_phase = 0;

  logic [15:0] threshold;
  int          run_max;
  logic [31:0] sum_exp;
  int          top_logit;
  int          top_label;
  int          cls_count;
  bit          have_top;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pow2_table(input logic [31:0] k);
    logic [31:0] tbl[17];
    tbl = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    return tbl[k];
  endfunction

  function automatic logic [31:0] neg_exp(input int d);
    logic [31:0] t, n, f, i, r, m, p0, p1;
    t = (d & 32'hFFFF) * 1477;
    n = t >> 20;
    f = t & 32'hFFFFF;
    i = f >> 16;
    r = f & 32'hFFFF;
    p0 = pow2_table(i);
    p1 = pow2_table(i + 1);
    m = p0 - (((p0 - p1) * r) >> 16);
    if (n >= 32) return 0;
    return m >> n;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

  task automatic clear_query();
    run_max = -32768;
    sum_exp = 0;
    top_logit = -32768;
    top_label = 0;
    cls_count = 0;
    have_top = 0;
  endtask

  task automatic predict_detection(input logit_txn_t tx);
    int x;
    logic [63:0] scaled, num, sc;
    int cx, cy, hw, hh;
    detection_t det;
    x = $signed(tx.data.logit);
    if (x > run_max) begin
      scaled = ({32'd0, sum_exp} * neg_exp(x - run_max)) >> 16;
      sum_exp = add_sat(scaled[31:0], 32'd65536);
      run_max = x;
    end else begin
      sum_exp = add_sat(sum_exp, neg_exp(run_max - x));
    end
    if (!tx.last) begin
      if (!have_top || x > top_logit) begin
        top_logit = x;
        top_label = cls_count;
        have_top = 1;
      end
      if (cls_count < MAX_CLS - 1) cls_count++;
      return;
    end
    if (have_top) begin
      num = {32'd0, neg_exp(run_max - top_logit)} << 16;
      sc = (sum_exp == 0) ? 0 : num / sum_exp;
      if (sc > 65535) sc = 65535;
      if (sc >= threshold) begin
        cx = tx.data.box_cx;
        cy = tx.data.box_cy;
        hw = tx.data.box_w >> 1;
        hh = tx.data.box_h >> 1;
        det.score = sc[15:0];
        det.label = top_label[6:0];
        det.x_min = 17'(cx - hw);
        det.y_min = 17'(cy - hh);
        det.x_max = 17'(cx + hw);
        det.y_max = 17'(cy + hh);
        expected_dets.push_back(det);
      end
    end
    clear_query();
  endtask

  function automatic logit_txn_t make_txn(input logic [15:0] lg, input bit last);
    logit_txn_t tx;
    tx.data.logit = lg;
    tx.data.box_cx = 16'($urandom);
    tx.data.box_cy = 16'($urandom);
    tx.data.box_w = 16'($urandom);
    tx.data.box_h = 16'($urandom);
    tx.last = last;
    return tx;
  endfunction

  function automatic logic [15:0] rand_logit(input int spread);
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'($urandom);
    if (p == 1) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return 16'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic queue_query(input int n_cls, input int spread, input bit peaked);
    int hot;
    logic [15:0] lg;
    hot = $urandom_range(0, n_cls > 1 ? n_cls - 2 : 0);
    for (int k = 0; k < n_cls; k++) begin
      lg = rand_logit(spread);
      if (peaked && k == hot) lg = 16'($urandom_range(6000, 12000));
      pending_logits.push_back(make_txn(lg, k == n_cls - 1));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_detection(pending_logits.pop_front());
        send_gap = gap_len();
      end
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (send_gap > 0) send_gap--;
        if (send_gap == 0 && !hold_send && pending_logits.size() > 0) begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= pending_logits[0].data;
          s_axis_tlast <= pending_logits[0].last;
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    detection_t got, want;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[90:0];
        if (expected_dets.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected detection %h", got);
        end else begin
          want = expected_dets.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp score %0d label %0d box %h %h %h %h, got score %0d label %0d box %h %h %h %h",
                       want.score, want.label, want.x_min, want.y_min, want.x_max, want.y_max,
                       got.score, got.label, got.x_min, got.y_min, got.x_max, got.y_max);
          end
        end
      end
      if (quiet_phase) begin
        m_axis_tready <= 1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        recv_gap = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("detr_query_postprocess_core test failed");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_logits.size() > 0 || s_axis_tvalid || expected_dets.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    threshold = v;
  endtask

  initial begin
    logic [15:0] settings[6];
    int n;
    threshold = 16'd32768;
    clear_query();
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: extremes, ties, no-object only, long query
    pending_logits.push_back(make_txn(16'h8000, 1));
    pending_logits.push_back(make_txn(16'h7FFF, 0));
    pending_logits.push_back(make_txn(16'h8000, 1));
    pending_logits.push_back(make_txn(16'h8000, 0));
    pending_logits.push_back(make_txn(16'h7FFF, 1));
    pending_logits.push_back(make_txn(16'd2048, 0));
    pending_logits.push_back(make_txn(16'd2048, 0));
    pending_logits.push_back(make_txn(16'hF000, 1));
    pending_logits.push_back(make_txn(16'd0, 0));
    pending_logits.push_back(make_txn(16'd0, 1));
    pending_logits.push_back(make_txn(16'h0400, 0));
    pending_logits.push_back(make_txn(16'hFFFF, 0));
    pending_logits.push_back(make_txn(16'h2000, 0));
    pending_logits.push_back(make_txn(16'h8000, 1));
    drain();

    write_threshold(16'd0);
    for (int k = 0; k < 130; k++)
      pending_logits.push_back(make_txn(k == 129 ? 16'h8000 : 16'($urandom_range(0, 3000)),
                                        k == 129));
    pending_logits.push_back(make_txn(16'h1234, 0));
    pending_logits.push_back(make_txn(16'h8000, 1));
    drain();

    settings = '{16'd0, 16'd65535, 16'd1, 16'd16384, 16'd50000, 16'd32768};
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      n = 0;
      while (n < 300) begin
        int nc;
        nc = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) quiet_phase = ~quiet_phase;
        end
        queue_query(nc, $urandom_range(0, 1) ? 2000 : 32767, $urandom_range(0, 2) != 0);
        n += nc;
        if ($urandom_range(0, 15) == 0) begin
          while (pending_logits.size() > 0) @(posedge clk);
          hold_send = 1;
          while (s_axis_tvalid) @(posedge clk);
          while (expected_dets.size() > 0) @(posedge clk);
          hold_send = 0;
        end
      end
      quiet_phase = 0;
      drain();
    end

    if (mismatches == 0 && expected_dets.size() == 0)
      $display("detr_query_postprocess_core test passed");
    else
      $display("detr_query_postprocess_core test failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/dqp_pkg.sv
rtl/dqp_exp.sv
rtl/dqp_div.sv
rtl/dqp_datapath.sv
rtl/dqp_ctrl.sv
rtl/detr_query_postprocess_core.sv
tb/detr_query_postprocess_core_test.sv
